// File: rtl/core/clns_pkg.sv
package clns_pkg;

  localparam int DDRAM_SPAN = 80;
  localparam int GLYPH_ROWS = 8;
  localparam int Q_DEPTH    = 2;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_CGRAM   = 8'h40;
  localparam logic [7:0] CMD_DDRAM   = 8'h80;
  localparam logic [7:0] ROW2_OFFSET = 8'h40;

  localparam logic [3:0] NIB_WAKE    = 4'h3;
  localparam logic [3:0] NIB_4BIT    = 4'h2;

  localparam logic [15:0] WAIT_POWER_US = 16'd41000;
  localparam logic [15:0] WAIT_SECOND_US = 16'd5000;
  localparam logic [15:0] WAIT_SHORT_US = 16'd200;

  localparam logic [15:0] SHORT_PULSE_RST = 16'd50;
  localparam logic [15:0] LONG_PULSE_RST  = 16'd2000;
  localparam logic [7:0]  FUNC_SET_RST    = 8'h28;
  localparam logic [7:0]  DISP_OFF_RST    = 8'h08;
  localparam logic [7:0]  ENTRY_MODE_RST  = 8'h06;
  localparam logic [7:0]  DISP_ON_RST     = 8'h0F;

  // Step numbers of the multi-pulse sequences.
  localparam logic [4:0] STEP_GLYPH_LAST = 5'(2 * (GLYPH_ROWS + 1) - 1);
  localparam logic [4:0] STEP_INIT_LAST  = 5'd15;
  localparam logic [4:0] STEP_INIT_BYTES = 5'd4;

  typedef enum logic [2:0] {
    REQ_CHAR   = 3'd0,
    REQ_CMD    = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_HOME   = 3'd3,
    REQ_LOCATE = 3'd4,
    REQ_GLYPH  = 3'd5,
    REQ_INIT   = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    CFG_SHORT_PULSE = 3'd0,
    CFG_LONG_PULSE  = 3'd1,
    CFG_FUNC_SET    = 3'd2,
    CFG_DISP_OFF    = 3'd3,
    CFG_ENTRY_MODE  = 3'd4,
    CFG_DISP_ON     = 3'd5,
    CFG_UNUSED6     = 3'd6,
    CFG_UNUSED7     = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_GLYPH = 2'd1,
    KIND_INIT  = 2'd2
  } kind_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    kind_t       kind;
    logic        rs;
    logic        long_p;
    logic [7:0]  byte_v;
    logic [63:0] rows;
  } desc_t;

  typedef struct packed {
    logic [15:0] short_pulse;
    logic [15:0] long_pulse;
    logic [7:0]  func_set;
    logic [7:0]  disp_off;
    logic [7:0]  entry_mode;
    logic [7:0]  disp_on;
  } cfg_t;

  typedef struct packed {
    logic  full;
    logic  empty;
  } q_stat_t;

endpackage

// File: rtl/core/clns_front.sv
module clns_front
  import clns_pkg::*;
(
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_data_byte,
  input  logic signed [7:0] in_row_req,
  input  logic signed [7:0] in_column_req,
  input  logic [7:0]        in_glyph_slot,
  input  logic [63:0]       in_glyph_rows,
  input  q_stat_t           q_stat,
  output logic              push,
  output desc_t             push_desc
);

  logic       row2;
  logic [7:0] col_m1;
  logic [7:0] loc_cmd;
  logic [2:0] slot;

  always_comb begin
    row2 = (in_row_req >= 8'sd2);
    if (in_column_req < 8'sd1) begin
      col_m1 = '0;
    end else if ($signed({in_column_req[7], in_column_req}) > $signed(9'(DDRAM_SPAN))) begin
      col_m1 = 8'(DDRAM_SPAN - 1);
    end else begin
      col_m1 = in_column_req - 8'sd1;
    end
    loc_cmd = (CMD_DDRAM | (row2 ? ROW2_OFFSET : 8'h00)) + col_m1;
    slot = (in_glyph_slot > 8'(GLYPH_ROWS - 1)) ? 3'(GLYPH_ROWS - 1) : in_glyph_slot[2:0];
  end

  always_comb begin
    push_desc.kind   = KIND_BYTE;
    push_desc.rs     = 1'b0;
    push_desc.long_p = 1'b0;
    push_desc.byte_v = in_data_byte;
    push_desc.rows   = in_glyph_rows;
    case (req_t'(in_req_type))
      REQ_CHAR: begin
        push_desc.rs = 1'b1;
      end
      REQ_CMD: begin
        push_desc.rs = 1'b0;
      end
      REQ_CLEAR: begin
        push_desc.byte_v = CMD_CLEAR;
        push_desc.long_p = 1'b1;
      end
      REQ_HOME: begin
        push_desc.byte_v = CMD_HOME;
        push_desc.long_p = 1'b1;
      end
      REQ_LOCATE: begin
        push_desc.byte_v = loc_cmd;
      end
      REQ_GLYPH: begin
        push_desc.kind   = KIND_GLYPH;
        push_desc.byte_v = CMD_CGRAM | {2'b00, slot, 3'b000};
      end
      REQ_INIT: begin
        push_desc.kind = KIND_INIT;
      end
      default: begin
        push_desc.kind = KIND_BYTE;
      end
    endcase
  end

  // The unused request type produces no pulses, so it is consumed and dropped here.
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready && (req_t'(in_req_type) != REQ_NONE);

endmodule

// File: rtl/core/clns_queue.sv
module clns_queue
  import clns_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  desc_t   push_desc,
  input  logic    pop,
  output desc_t   head,
  output q_stat_t q_stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  desc_t              q_mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head         = q_mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(Q_DEPTH)))
    else $error("queue pushed while full");

endmodule

// File: rtl/core/clns_back.sv
module clns_back
  import clns_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  desc_t       head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_select,
  output logic [3:0]  out_nibble,
  output logic [15:0] out_wait_before_us,
  output logic [15:0] out_pulse_us,
  output logic        out_last
);

  desc_t       cur_r;
  logic        busy_r;
  logic [4:0]  step_r;
  logic        out_valid_r;
  logic        rs_r;
  logic [3:0]  nib_r;
  logic [15:0] wait_r;
  logic [15:0] pulse_r;
  logic        last_r;

  desc_t       src;
  logic [4:0]  stp;
  logic [4:0]  init_j;
  logic [3:0]  byte_idx;
  logic [2:0]  row_idx;
  logic [7:0]  cur_byte;
  logic        p_rs;
  logic        p_long;
  logic        p_last;
  logic [3:0]  p_nib;
  logic [15:0] p_wait;
  logic        have_work;
  logic        advance;

  always_comb begin
    src      = busy_r ? cur_r : head;
    stp      = busy_r ? step_r : '0;
    init_j   = stp - STEP_INIT_BYTES;
    byte_idx = stp[4:1];
    row_idx  = 3'(byte_idx - 4'd1);
    cur_byte = src.byte_v;
    p_rs     = src.rs;
    p_long   = src.long_p;
    p_last   = stp[0];
    p_wait   = '0;
    p_nib    = '0;
    case (src.kind)
      KIND_BYTE: begin
        p_nib = stp[0] ? cur_byte[3:0] : cur_byte[7:4];
      end
      KIND_GLYPH: begin
        p_rs   = 1'b0;
        p_long = 1'b0;
        if (byte_idx != 4'd0) begin
          cur_byte = src.rows[{row_idx, 3'b000} +: 8];
          p_rs     = 1'b1;
        end
        p_nib  = stp[0] ? cur_byte[3:0] : cur_byte[7:4];
        p_last = (stp == STEP_GLYPH_LAST);
      end
      KIND_INIT: begin
        p_rs   = 1'b0;
        p_long = 1'b0;
        p_last = (stp == STEP_INIT_LAST);
        if (stp < STEP_INIT_BYTES) begin
          p_nib = (stp == STEP_INIT_BYTES - 5'd1) ? NIB_4BIT : NIB_WAKE;
          case (stp[1:0])
            2'd0:    p_wait = WAIT_POWER_US;
            2'd1:    p_wait = WAIT_SECOND_US;
            default: p_wait = WAIT_SHORT_US;
          endcase
        end else begin
          case (init_j[3:1])
            3'd0:    cur_byte = cfg.func_set;
            3'd1:    cur_byte = cfg.disp_off;
            3'd2: begin
              cur_byte = CMD_CLEAR;
              p_long   = 1'b1;
            end
            3'd3:    cur_byte = cfg.entry_mode;
            3'd4:    cur_byte = cfg.disp_on;
            default: cur_byte = CMD_DDRAM;
          endcase
          p_nib  = init_j[0] ? cur_byte[3:0] : cur_byte[7:4];
          p_wait = (stp == STEP_INIT_BYTES) ? WAIT_SHORT_US : 16'd0;
        end
      end
      default: begin
        p_nib = cur_byte[3:0];
      end
    endcase
  end

  // The output register is refilled whenever it is empty or being drained.
  assign have_work = busy_r || !q_stat.empty;
  assign advance   = have_work && (!out_valid_r || out_ready);
  assign pop       = advance && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= have_work;
      end
      if (advance) begin
        busy_r <= !p_last;
        step_r <= stp + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (advance) begin
      rs_r    <= p_rs;
      nib_r   <= p_nib;
      wait_r  <= p_wait;
      pulse_r <= p_long ? cfg.long_pulse : cfg.short_pulse;
      last_r  <= p_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reg_select     = rs_r;
  assign out_nibble         = nib_r;
  assign out_wait_before_us = wait_r;
  assign out_pulse_us       = pulse_r;
  assign out_last           = last_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= STEP_GLYPH_LAST))
    else $error("sequence step out of range");

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && (busy_r || last_r)))
    else $error("started request produced no pulse");

endmodule

// File: rtl/core/char_lcd_nibble_sequencer_core.sv
// Character LCD 4-bit bus sequencer.
// Input channel (in_*): one request per transaction: char, command, clear, home,
// locate, create glyph or init. Request type 7 is accepted and produces nothing.
// Output channel (out_*): one transaction per enable pulse, giving RS, the nibble,
// the idle wait before the pulse and the enable time; out_last marks the final
// pulse of a request. Char, command, clear, home and locate give 2 pulses, create
// glyph gives 18 and init gives 16.
// Configuration channel (cfg_*): register index and data; always ready. Write it
// only while no request is in flight.
// With the sequencer idle, an accepted request is written into the queue and its
// first pulse is then loaded into the output register. The back sequencer emits one
// pulse per cycle while the receiver takes them, with no gap between requests. A
// two-entry queue between the classifier and the sequencer keeps input accepted
// while pulses are produced.
// When the receiver stalls, the output register holds its pulse and the sequencer
// waits; input keeps being accepted until the queue fills.
// Synchronous reset clears the queue and sequencer and restores the register
// defaults (50 us, 2000 us, 0x28, 0x08, 0x06, 0x0F).
module char_lcd_nibble_sequencer_core
  import clns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_data_byte,
  input  logic signed [7:0] in_row_req,
  input  logic signed [7:0] in_column_req,
  input  logic [7:0]        in_glyph_slot,
  input  logic [63:0]       in_glyph_rows,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_reg_select,
  output logic [3:0]        out_nibble,
  output logic [15:0]       out_wait_before_us,
  output logic [15:0]       out_pulse_us,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  cfg_t    cfg_r;
  q_stat_t q_stat;
  desc_t   push_desc;
  desc_t   head;
  logic    push;
  logic    pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_pulse <= SHORT_PULSE_RST;
      cfg_r.long_pulse  <= LONG_PULSE_RST;
      cfg_r.func_set    <= FUNC_SET_RST;
      cfg_r.disp_off    <= DISP_OFF_RST;
      cfg_r.entry_mode  <= ENTRY_MODE_RST;
      cfg_r.disp_on     <= DISP_ON_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHORT_PULSE: cfg_r.short_pulse <= cfg_data;
        CFG_LONG_PULSE:  cfg_r.long_pulse  <= cfg_data;
        CFG_FUNC_SET:    cfg_r.func_set    <= cfg_data[7:0];
        CFG_DISP_OFF:    cfg_r.disp_off    <= cfg_data[7:0];
        CFG_ENTRY_MODE:  cfg_r.entry_mode  <= cfg_data[7:0];
        CFG_DISP_ON:     cfg_r.disp_on     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  clns_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_data_byte  (in_data_byte),
    .in_row_req    (in_row_req),
    .in_column_req (in_column_req),
    .in_glyph_slot (in_glyph_slot),
    .in_glyph_rows (in_glyph_rows),
    .q_stat        (q_stat),
    .push          (push),
    .push_desc     (push_desc)
  );

  clns_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  clns_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .head               (head),
    .q_stat             (q_stat),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reg_select     (out_reg_select),
    .out_nibble         (out_nibble),
    .out_wait_before_us (out_wait_before_us),
    .out_pulse_us       (out_pulse_us),
    .out_last           (out_last)
  );

endmodule

// File: tb/char_lcd_nibble_sequencer_checker.sv
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_checker
  import clns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_data_byte,
  input  logic signed [7:0] in_row_req,
  input  logic signed [7:0] in_column_req,
  input  logic [7:0]        in_glyph_slot,
  input  logic [63:0]       in_glyph_rows,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_reg_select,
  input  logic [3:0]        out_nibble,
  input  logic [15:0]       out_wait_before_us,
  input  logic [15:0]       out_pulse_us,
  input  logic              out_last,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                fail_count,
  output int                pending_count,
  output int                pulses_checked
);

  // Keeps the report readable when the block is badly broken; every mismatch is still counted.
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [15:0] pulse_us;
    logic        last;
  } pulse_t;

  pulse_t expected_pulses[$];
  cfg_t   lcd_cfg;

  task automatic push_nibble(input logic rs, input logic [3:0] nib,
                             input logic [15:0] wait_us, input logic [15:0] pulse);
    pulse_t p;
    p.reg_select     = rs;
    p.nibble         = nib;
    p.wait_before_us = wait_us;
    p.pulse_us       = pulse;
    p.last           = 1'b0;
    expected_pulses.push_back(p);
  endtask

  // The wait applies only to the first nibble of the byte.
  task automatic push_byte(input logic rs, input logic [7:0] byte_v,
                           input logic [15:0] wait_us, input logic [15:0] pulse);
    push_nibble(rs, byte_v[7:4], wait_us, pulse);
    push_nibble(rs, byte_v[3:0], 16'd0, pulse);
  endtask

  function automatic logic [7:0] ddram_address(input int row_in, input int col_in);
    int row;
    int col;
    int addr;
    row = (row_in > 2) ? 2 : (row_in < 1) ? 1 : row_in;
    col = (col_in > DDRAM_SPAN) ? DDRAM_SPAN : (col_in < 1) ? 1 : col_in;
    addr = CMD_DDRAM;
    if (row == 2) begin
      addr = addr | ROW2_OFFSET;
    end
    // Columns near the end of row 2 wrap past 8 bits; only the low byte is sent.
    addr = addr + col - 1;
    return addr[7:0];
  endfunction

  task automatic predict_pulses();
    int     first;
    int     slot;
    pulse_t tail;
    first = expected_pulses.size();
    case (req_t'(in_req_type))
      REQ_CHAR:   push_byte(1'b1, in_data_byte, 16'd0, lcd_cfg.short_pulse);
      REQ_CMD:    push_byte(1'b0, in_data_byte, 16'd0, lcd_cfg.short_pulse);
      REQ_CLEAR:  push_byte(1'b0, CMD_CLEAR, 16'd0, lcd_cfg.long_pulse);
      REQ_HOME:   push_byte(1'b0, CMD_HOME, 16'd0, lcd_cfg.long_pulse);
      REQ_LOCATE: begin
        push_byte(1'b0, ddram_address(in_row_req, in_column_req), 16'd0,
                  lcd_cfg.short_pulse);
      end
      REQ_GLYPH: begin
        slot = (in_glyph_slot > GLYPH_ROWS - 1) ? GLYPH_ROWS - 1 : in_glyph_slot;
        push_byte(1'b0, 8'(CMD_CGRAM + slot * 8), 16'd0, lcd_cfg.short_pulse);
        for (int i = 0; i < GLYPH_ROWS; i++) begin
          push_byte(1'b1, in_glyph_rows[8*i +: 8], 16'd0, lcd_cfg.short_pulse);
        end
      end
      REQ_INIT: begin
        push_nibble(1'b0, NIB_WAKE, WAIT_POWER_US, lcd_cfg.short_pulse);
        push_nibble(1'b0, NIB_WAKE, WAIT_SECOND_US, lcd_cfg.short_pulse);
        push_nibble(1'b0, NIB_WAKE, WAIT_SHORT_US, lcd_cfg.short_pulse);
        push_nibble(1'b0, NIB_4BIT, WAIT_SHORT_US, lcd_cfg.short_pulse);
        push_byte(1'b0, lcd_cfg.func_set, WAIT_SHORT_US, lcd_cfg.short_pulse);
        push_byte(1'b0, lcd_cfg.disp_off, 16'd0, lcd_cfg.short_pulse);
        push_byte(1'b0, CMD_CLEAR, 16'd0, lcd_cfg.long_pulse);
        push_byte(1'b0, lcd_cfg.entry_mode, 16'd0, lcd_cfg.short_pulse);
        push_byte(1'b0, lcd_cfg.disp_on, 16'd0, lcd_cfg.short_pulse);
        push_byte(1'b0, ddram_address(1, 1), 16'd0, lcd_cfg.short_pulse);
      end
      default: ;
    endcase
    if (expected_pulses.size() > first) begin
      tail = expected_pulses.pop_back();
      tail.last = 1'b1;
      expected_pulses.push_back(tail);
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: pulse %0d %s mismatch: expected %0h, actual %0h",
                 $time, pulses_checked, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    pulse_t want;
    if (!rst_n) begin
      expected_pulses.delete();
      lcd_cfg.short_pulse = SHORT_PULSE_RST;
      lcd_cfg.long_pulse  = LONG_PULSE_RST;
      lcd_cfg.func_set    = FUNC_SET_RST;
      lcd_cfg.disp_off    = DISP_OFF_RST;
      lcd_cfg.entry_mode  = ENTRY_MODE_RST;
      lcd_cfg.disp_on     = DISP_ON_RST;
      fail_count     = 0;
      pulses_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SHORT_PULSE: lcd_cfg.short_pulse = cfg_data;
          CFG_LONG_PULSE:  lcd_cfg.long_pulse  = cfg_data;
          CFG_FUNC_SET:    lcd_cfg.func_set    = cfg_data[7:0];
          CFG_DISP_OFF:    lcd_cfg.disp_off    = cfg_data[7:0];
          CFG_ENTRY_MODE:  lcd_cfg.entry_mode  = cfg_data[7:0];
          CFG_DISP_ON:     lcd_cfg.disp_on     = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pulses.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: unexpected pulse: expected none, actual rs %0b nibble %0h last %0b",
                     $time, out_reg_select, out_nibble, out_last);
          end
        end else begin
          want = expected_pulses.pop_front();
          check_field("reg_select", 16'(want.reg_select), 16'(out_reg_select));
          check_field("nibble", 16'(want.nibble), 16'(out_nibble));
          check_field("wait_before_us", want.wait_before_us, out_wait_before_us);
          check_field("pulse_us", want.pulse_us, out_pulse_us);
          check_field("last", 16'(want.last), 16'(out_last));
          pulses_checked++;
        end
      end
      if (in_valid && in_ready) begin
        predict_pulses();
      end
    end
    pending_count = expected_pulses.size();
  end

endmodule

// File: tb/char_lcd_nibble_sequencer_core_tb.sv
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_core_tb;
  import clns_pkg::*;

  localparam int RANDOM_REQUESTS = 270;
  localparam int PHASES          = 5;
  localparam int DRAIN_CYCLES    = 20;
  // Worst case is about 360 requests of 18 pulses, each pulse behind the longest output stall.
  localparam int CYCLE_LIMIT     = 1_500_000;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [2:0]        in_req_type   = REQ_NONE;
  logic [7:0]        in_data_byte  = '0;
  logic signed [7:0] in_row_req    = '0;
  logic signed [7:0] in_column_req = '0;
  logic [7:0]        in_glyph_slot = '0;
  logic [63:0]       in_glyph_rows = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic              out_reg_select;
  logic [3:0]        out_nibble;
  logic [15:0]       out_wait_before_us;
  logic [15:0]       out_pulse_us;
  logic              out_last;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index     = '0;
  logic [15:0]       cfg_data      = '0;

  int fail_count;
  int pending_count;
  int pulses_checked;
  int cycle_count   = 0;
  int requests_sent = 0;
  int settings_used = 1;
  bit in_burst      = 1'b0;

  always #1 clk = ~clk;

  char_lcd_nibble_sequencer_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_data_byte       (in_data_byte),
    .in_row_req         (in_row_req),
    .in_column_req      (in_column_req),
    .in_glyph_slot      (in_glyph_slot),
    .in_glyph_rows      (in_glyph_rows),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reg_select     (out_reg_select),
    .out_nibble         (out_nibble),
    .out_wait_before_us (out_wait_before_us),
    .out_pulse_us       (out_pulse_us),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  char_lcd_nibble_sequencer_checker pulse_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_data_byte       (in_data_byte),
    .in_row_req         (in_row_req),
    .in_column_req      (in_column_req),
    .in_glyph_slot      (in_glyph_slot),
    .in_glyph_rows      (in_glyph_rows),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reg_select     (out_reg_select),
    .out_nibble         (out_nibble),
    .out_wait_before_us (out_wait_before_us),
    .out_pulse_us       (out_pulse_us),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending_count      (pending_count),
    .pulses_checked     (pulses_checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a rising edge; returns at a rising edge with the transaction accepted.
  // Handshake signals are sampled at the falling edge, where everything has settled.
  task automatic send_request(input req_t req, input logic [7:0] data,
                              input logic [7:0] row, input logic [7:0] col,
                              input logic [7:0] slot, input logic [63:0] rows);
    int gap;
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_data_byte  <= data;
    in_row_req    <= row;
    in_column_req <= col;
    in_glyph_slot <= slot;
    in_glyph_rows <= rows;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    requests_sent++;
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_request(output req_t req);
    int         v;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] slot;
    req = req_t'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) begin
      v   = $urandom_range(0, 5) - 1;
      row = v[7:0];
      v   = $urandom_range(0, DDRAM_SPAN + 4) - 2;
      col = v[7:0];
    end else begin
      row = 8'($urandom);
      col = 8'($urandom);
    end
    slot = $urandom_range(0, 1) ? 8'($urandom_range(0, 9)) : 8'($urandom);
    send_request(req, 8'($urandom), row, col, slot, {$urandom, $urandom});
  endtask

  // Every result has arrived; the bench then waits out DRAIN_CYCLES before the registers are touched.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all six registers and both unused indexes back to back.
  task automatic write_settings(input logic [15:0] short_us, input logic [15:0] long_us,
                                input logic [7:0] func_set, input logic [7:0] disp_off,
                                input logic [7:0] entry_mode, input logic [7:0] disp_on);
    logic [15:0] values[8];
    values = '{short_us, long_us, 16'(func_set), 16'(disp_off), 16'(entry_mode),
               16'(disp_on), 16'($urandom), 16'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= values[i];
      @(negedge clk);
      while (!cfg_ready) @(negedge clk);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : out_side
    int run;
    int gap;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pulses outstanding",
               cycle_count, pending_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : in_side
    req_t req;
    int   counted;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset register values.
    send_request(REQ_CHAR,   8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_request(REQ_CHAR,   8'hFF, 8'hFF, 8'hFF, 8'hFF, '1);
    send_request(REQ_CMD,    8'h5A, 8'h00, 8'h00, 8'h00, 64'h0);
    send_request(REQ_CMD,    8'hA5, 8'h00, 8'h00, 8'h00, 64'h0);
    send_request(REQ_CLEAR,  8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_request(REQ_HOME,   8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_request(REQ_LOCATE, 8'h00, 8'd1, 8'd1, 8'h00, 64'h0);
    send_request(REQ_LOCATE, 8'h00, 8'd2, 8'd1, 8'h00, 64'h0);
    send_request(REQ_LOCATE, 8'h00, 8'd2, 8'd80, 8'h00, 64'h0);
    send_request(REQ_LOCATE, 8'h00, 8'd1, 8'd80, 8'h00, 64'h0);
    send_request(REQ_LOCATE, 8'h00, 8'h80, 8'h80, 8'h00, 64'h0);
    send_request(REQ_LOCATE, 8'h00, 8'h7F, 8'h7F, 8'h00, 64'h0);
    send_request(REQ_LOCATE, 8'h00, 8'd0, 8'd81, 8'h00, 64'h0);
    send_request(REQ_LOCATE, 8'h00, 8'd3, 8'd0, 8'h00, 64'h0);
    send_request(REQ_GLYPH,  8'h00, 8'h00, 8'h00, 8'd0, 64'h0);
    send_request(REQ_GLYPH,  8'h00, 8'h00, 8'h00, 8'd7, '1);
    send_request(REQ_GLYPH,  8'h00, 8'h00, 8'h00, 8'd8, 64'h0123_4567_89AB_CDEF);
    send_request(REQ_GLYPH,  8'h00, 8'h00, 8'h00, 8'hFF, {$urandom, $urandom});
    send_request(REQ_INIT,   8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_request(REQ_NONE,   8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    send_request(REQ_CHAR,   8'h41, 8'h00, 8'h00, 8'h00, 64'h0);
    send_request(REQ_INIT,   8'hFF, 8'h7F, 8'h80, 8'hFF, '1);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_idle();
      case (phase)
        0:       write_settings(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        1:       write_settings(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        2:       write_settings(16'd1, 16'd65534, 8'h2C, 8'h08, 8'h07, 8'h0C);
        default: write_settings(16'($urandom), 16'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // Requests of type 7 make no pulses and do not count toward the phase.
      counted = 0;
      while (counted < RANDOM_REQUESTS / PHASES) begin
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
        send_random_request(req);
        if (req != REQ_NONE) counted++;
      end
    end

    wait_for_idle();
    $display("Sent %0d requests of all types under %0d register settings; %0d pulses checked",
             requests_sent, settings_used, pulses_checked);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/clns_pkg.sv
rtl/core/clns_front.sv
rtl/core/clns_queue.sv
rtl/core/clns_back.sv
rtl/core/char_lcd_nibble_sequencer_core.sv
tb/char_lcd_nibble_sequencer_checker.sv
tb/char_lcd_nibble_sequencer_core_tb.sv
